[hw/rtl/bcgp_pkg.sv]
// ============================================================================
// bcgp_pkg: shared types and constants for the grid point generator
// Coordinate, weight and corner set types, register indexes and formats.
// ============================================================================
`default_nettype none

package bcgp_pkg;

    // Grid size defaults and index width of the input beat.
    localparam int GRID_COLS_DEF = 16;
    localparam int GRID_ROWS_DEF = 16;
    localparam int IDX_W         = 4;
    localparam int IDX_COUNT     = 1 << IDX_W;

    // Fixed point formats: 12.4 coordinates, Q1.16 weights, Q1.32 products.
    localparam int COORD_W   = 16;
    localparam int WEIGHT_W  = 17;
    localparam int PWEIGHT_W = 33;
    localparam int ONE_Q16   = 65536;
    localparam int PROD_W    = COORD_W + PWEIGHT_W + 1;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [WEIGHT_W-1:0]       weight_t;
    typedef logic [PWEIGHT_W-1:0]      pweight_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // Four corners of one axis.
    typedef struct packed {
        coord_t tl;
        coord_t tr;
        coord_t bl;
        coord_t br;
    } quad_t;

    // Four bilinear product weights, Q1.32, summing to one.
    typedef struct packed {
        pweight_t w00;
        pweight_t w10;
        pweight_t w01;
        pweight_t w11;
    } weight_set_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TL_X = 3'd0,
        REG_TL_Y = 3'd1,
        REG_TR_X = 3'd2,
        REG_TR_Y = 3'd3,
        REG_BL_X = 3'd4,
        REG_BL_Y = 3'd5,
        REG_BR_X = 3'd6,
        REG_BR_Y = 3'd7
    } cfg_reg_t;

endpackage

`default_nettype wire

[hw/rtl/bcgp_weight.sv]
// ============================================================================
// bcgp_weight: weight generation stages
// Looks up the column and row weights, then forms the four product weights.
// ============================================================================
`default_nettype none

module bcgp_weight #(
    parameter int GRID_COLS = bcgp_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = bcgp_pkg::GRID_ROWS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [bcgp_pkg::IDX_W-1:0] grid_col,
    input  wire logic [bcgp_pkg::IDX_W-1:0] grid_row,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output bcgp_pkg::weight_set_t           out_weights
);

    localparam int ColDen = GRID_COLS - 1;
    localparam int RowDen = GRID_ROWS - 1;

    bcgp_pkg::weight_t col_tab [bcgp_pkg::IDX_COUNT];
    bcgp_pkg::weight_t row_tab [bcgp_pkg::IDX_COUNT];

    // Constant weight tables, clamped index, rounded Q1.16 quotient.
    for (genvar i = 0; i < bcgp_pkg::IDX_COUNT; i++) begin : g_tab
        localparam int ColIdx = (i > ColDen) ? ColDen : i;
        localparam int RowIdx = (i > RowDen) ? RowDen : i;
        localparam int ColW   = (ColIdx * bcgp_pkg::ONE_Q16 + ColDen / 2) / ColDen;
        localparam int RowW   = (RowIdx * bcgp_pkg::ONE_Q16 + RowDen / 2) / RowDen;
        assign col_tab[i] = bcgp_pkg::weight_t'(ColW);
        assign row_tab[i] = bcgp_pkg::weight_t'(RowW);
    end

    logic                  va_reg;
    bcgp_pkg::weight_t     a_reg;
    bcgp_pkg::weight_t     b_reg;
    logic                  vb_reg;
    bcgp_pkg::weight_set_t w_reg;
    logic                  ready_a;
    logic                  ready_b;
    bcgp_pkg::weight_t     na;
    bcgp_pkg::weight_t     nb;
    logic [2*bcgp_pkg::WEIGHT_W-1:0] p00;
    logic [2*bcgp_pkg::WEIGHT_W-1:0] p10;
    logic [2*bcgp_pkg::WEIGHT_W-1:0] p01;
    logic [2*bcgp_pkg::WEIGHT_W-1:0] p11;
    bcgp_pkg::weight_set_t w_next;

    // Each stage takes a beat when it is empty or its successor moves on.
    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    // Stage A: table lookup of the column and row weights.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ready_a) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready_a) begin
            a_reg <= col_tab[grid_col];
            b_reg <= row_tab[grid_row];
        end
    end

    // Stage B: complements and the four product weights.
    always_comb begin
        na  = bcgp_pkg::weight_t'(bcgp_pkg::ONE_Q16) - a_reg;
        nb  = bcgp_pkg::weight_t'(bcgp_pkg::ONE_Q16) - b_reg;
        p00 = na * nb;
        p10 = a_reg * nb;
        p01 = na * b_reg;
        p11 = a_reg * b_reg;
        w_next.w00 = p00[bcgp_pkg::PWEIGHT_W-1:0];
        w_next.w10 = p10[bcgp_pkg::PWEIGHT_W-1:0];
        w_next.w01 = p01[bcgp_pkg::PWEIGHT_W-1:0];
        w_next.w11 = p11[bcgp_pkg::PWEIGHT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (ready_b) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (va_reg && ready_b) begin
            w_reg <= w_next;
        end
    end

    assign out_valid   = vb_reg;
    assign out_weights = w_reg;

    // The product weights of a held beat always sum to exactly one.
    a_weight_sum : assert property (@(posedge aclk) disable iff (!aresetn)
        vb_reg |-> (35'(w_reg.w00) + 35'(w_reg.w10) + 35'(w_reg.w01)
                    + 35'(w_reg.w11)) == 35'h1_0000_0000)
        else $error("product weights do not sum to one");

    // Looked-up weights never exceed one.
    a_weight_range : assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg |-> (a_reg <= bcgp_pkg::weight_t'(bcgp_pkg::ONE_Q16))
                && (b_reg <= bcgp_pkg::weight_t'(bcgp_pkg::ONE_Q16)))
        else $error("column or row weight above one");

endmodule

`default_nettype wire

[hw/rtl/bcgp_blend.sv]
// ============================================================================
// bcgp_blend: corner blending stages
// Multiplies corners by product weights, sums, rounds and saturates.
// ============================================================================
`default_nettype none

module bcgp_blend (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire bcgp_pkg::weight_set_t in_weights,
    input  wire bcgp_pkg::quad_t       corner_x,
    input  wire bcgp_pkg::quad_t       corner_y,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output bcgp_pkg::coord_t           point_x,
    output bcgp_pkg::coord_t           point_y
);

    localparam int PairW = bcgp_pkg::PROD_W + 1;
    localparam int SumW  = bcgp_pkg::PROD_W + 2;
    localparam int QW    = SumW - 32;
    localparam logic signed [SumW-1:0] RoundHalf = SumW'(64'sd2147483648);

    // Round to nearest and clamp to the signed coordinate range.
    function automatic bcgp_pkg::coord_t round_sat(input logic signed [SumW-1:0] s);
        logic signed [SumW-1:0] r;
        logic signed [QW-1:0]   q;
        r = s + RoundHalf;
        q = r[SumW-1:32];
        if (q > QW'(32767)) begin
            return bcgp_pkg::coord_t'(16'sh7FFF);
        end else if (q < -QW'(32768)) begin
            return bcgp_pkg::coord_t'(16'sh8000);
        end else begin
            return q[bcgp_pkg::COORD_W-1:0];
        end
    endfunction

    logic                   vc_reg;
    logic                   vd_reg;
    logic                   ve_reg;
    logic                   ready_c;
    logic                   ready_d;
    logic                   ready_e;
    bcgp_pkg::prod_t        prod_x_reg [4];
    bcgp_pkg::prod_t        prod_y_reg [4];
    bcgp_pkg::prod_t        prod_x_next [4];
    bcgp_pkg::prod_t        prod_y_next [4];
    logic signed [PairW-1:0] pair_x_reg [2];
    logic signed [PairW-1:0] pair_y_reg [2];
    bcgp_pkg::coord_t       point_x_reg;
    bcgp_pkg::coord_t       point_y_reg;
    bcgp_pkg::coord_t       cx [4];
    bcgp_pkg::coord_t       cy [4];
    bcgp_pkg::pweight_t     wv [4];

    assign ready_e  = !ve_reg || out_ready;
    assign ready_d  = !vd_reg || ready_e;
    assign ready_c  = !vc_reg || ready_d;
    assign in_ready = ready_c;

    // Stage C: one corner times one product weight per multiplier.
    always_comb begin
        cx[0] = corner_x.tl;
        cx[1] = corner_x.tr;
        cx[2] = corner_x.bl;
        cx[3] = corner_x.br;
        cy[0] = corner_y.tl;
        cy[1] = corner_y.tr;
        cy[2] = corner_y.bl;
        cy[3] = corner_y.br;
        wv[0] = in_weights.w00;
        wv[1] = in_weights.w10;
        wv[2] = in_weights.w01;
        wv[3] = in_weights.w11;
        for (int k = 0; k < 4; k++) begin
            prod_x_next[k] = $signed(cx[k]) * $signed({1'b0, wv[k]});
            prod_y_next[k] = $signed(cy[k]) * $signed({1'b0, wv[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (ready_c) begin
                vc_reg <= in_valid;
            end
            if (ready_d) begin
                vd_reg <= vc_reg;
            end
            if (ready_e) begin
                ve_reg <= vd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready_c) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
    end

    // Stage D: pairwise sums of the products.
    always_ff @(posedge aclk) begin
        if (vc_reg && ready_d) begin
            pair_x_reg[0] <= PairW'(prod_x_reg[0]) + PairW'(prod_x_reg[1]);
            pair_x_reg[1] <= PairW'(prod_x_reg[2]) + PairW'(prod_x_reg[3]);
            pair_y_reg[0] <= PairW'(prod_y_reg[0]) + PairW'(prod_y_reg[1]);
            pair_y_reg[1] <= PairW'(prod_y_reg[2]) + PairW'(prod_y_reg[3]);
        end
    end

    // Stage E: final sum, rounding and saturation into the output register.
    always_ff @(posedge aclk) begin
        if (vd_reg && ready_e) begin
            point_x_reg <= round_sat(SumW'(pair_x_reg[0]) + SumW'(pair_x_reg[1]));
            point_y_reg <= round_sat(SumW'(pair_y_reg[0]) + SumW'(pair_y_reg[1]));
        end
    end

    assign out_valid = ve_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;

    // A beat leaving stage D always lands in the output register.
    a_stage_e_fill : assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg && ready_e |=> ve_reg)
        else $error("beat lost between sum and output stages");

    // The input side only stalls when every stage is full and blocked.
    a_full_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> vc_reg && vd_reg && ve_reg && !out_ready)
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

[hw/rtl/bilinear_corner_grid_point.sv]
// ============================================================================
// bilinear_corner_grid_point: warp mesh grid point generator
// Bilinear interpolation of a grid point between four configured corners.
// ============================================================================
// The block accepts one grid column and row per clock and returns one
// interpolated point per clock while the output is not stalled. A beat
// passes through five register stages: weight lookup, product weights,
// corner multiplies, pairwise sums, and the final sum with rounding and
// saturation. Every stage holds its own valid bit, so a stall on the
// result side fills empty stages before the input side stops. The user
// is to write corners through the configuration port while no beat is in
// flight; the block itself does not enforce this.
`default_nettype none

module bilinear_corner_grid_point #(
    parameter int GRID_COLS = bcgp_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = bcgp_pkg::GRID_ROWS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [bcgp_pkg::IDX_W-1:0]     s_grid_col,
    input  wire logic [bcgp_pkg::IDX_W-1:0]     s_grid_row,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [bcgp_pkg::COORD_W-1:0] m_point_x,
    output logic signed [bcgp_pkg::COORD_W-1:0] m_point_y,
    input  wire logic                           cfg_we,
    input  wire logic [bcgp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcgp_pkg::COORD_W-1:0]   cfg_data
);

    bcgp_pkg::quad_t       corner_x_reg;
    bcgp_pkg::quad_t       corner_y_reg;
    logic                  w_valid;
    logic                  w_ready;
    bcgp_pkg::weight_set_t w_set;

    // Corner registers, written one at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_x_reg <= '0;
            corner_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (bcgp_pkg::cfg_reg_t'(cfg_index))
                bcgp_pkg::REG_TL_X: corner_x_reg.tl <= cfg_data;
                bcgp_pkg::REG_TL_Y: corner_y_reg.tl <= cfg_data;
                bcgp_pkg::REG_TR_X: corner_x_reg.tr <= cfg_data;
                bcgp_pkg::REG_TR_Y: corner_y_reg.tr <= cfg_data;
                bcgp_pkg::REG_BL_X: corner_x_reg.bl <= cfg_data;
                bcgp_pkg::REG_BL_Y: corner_y_reg.bl <= cfg_data;
                bcgp_pkg::REG_BR_X: corner_x_reg.br <= cfg_data;
                bcgp_pkg::REG_BR_Y: corner_y_reg.br <= cfg_data;
            endcase
        end
    end

    // Weight stages.
    bcgp_weight #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_weight (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .grid_col    (s_grid_col),
        .grid_row    (s_grid_row),
        .out_valid   (w_valid),
        .out_ready   (w_ready),
        .out_weights (w_set)
    );

    // Blend stages and output register.
    bcgp_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (w_valid),
        .in_ready   (w_ready),
        .in_weights (w_set),
        .corner_x   (corner_x_reg),
        .corner_y   (corner_y_reg),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .point_x    (m_point_x),
        .point_y    (m_point_y)
    );

    // The input side can only block while a finished point waits.
    a_top_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input blocked while output is free");

endmodule

`default_nettype wire
